[design/timed_output_pattern_queue_assert.svh]
// Assertion macros used by the checker file.
// Each macro clocks on clk and is disabled while rst_n is low.
`ifndef TIMED_OUTPUT_PATTERN_QUEUE_ASSERT_SVH
`define TIMED_OUTPUT_PATTERN_QUEUE_ASSERT_SVH

// Same-cycle implication
`define TOPQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timed output queue check failed");

// Next-cycle implication
`define TOPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timed output queue check failed");

`endif

[design/topq_pkg.sv]
// ----------------------------------------------------------------------------
// topq_pkg
// Types, codes and defaults shared by the timed output pattern queue.
// ----------------------------------------------------------------------------
`default_nettype none

package topq_pkg;

    // Default sizes
    localparam int DEF_QUEUE_SLOTS   = 4;
    localparam int DEF_PATTERN_STEPS = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_POLARITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_AFTER_RESET  = 1'b1;

    // Request modes
    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_OFF    = 3'd1;
    localparam logic [2:0] MODE_ON     = 3'd2;
    localparam logic [2:0] MODE_TOGGLE = 3'd3;
    localparam logic [2:0] MODE_PRESS  = 3'd4;
    localparam logic [2:0] MODE_FLASH  = 3'd5;

    typedef enum logic [1:0] {
        SLOT_FREE,
        SLOT_FILLING,
        SLOT_WAITING
    } slot_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_RUN,
        ST_APPLY,
        ST_WR2,
        ST_RESULT
    } ctrl_state_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [23:0] duration;
        logic        is_first;
        logic        is_last;
        logic [15:0] repeat_count;
        logic [23:0] total_duration;
    } in_t;

    typedef struct packed {
        logic       pin_level;
        logic       output_on;
        logic [2:0] pending;
        logic       accepted;
    } out_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan_inc;
        logic scan_take;
        logic read;
        logic run;
        logic apply;
        logic wr2;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_tick;
        logic is_press;
        logic is_flash;
        logic want_scan;
        logic scan_hit;
        logic scan_last;
        logic sel_pattern;
        logic found;
    } sts_t;

endpackage

`default_nettype wire

[design/topq_ram.sv]
// ----------------------------------------------------------------------------
// topq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module topq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/topq_ctrl.sv]
// ----------------------------------------------------------------------------
// topq_ctrl
// Sequencer: accept, slot scan, step read, run, apply, second write, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module topq_ctrl
    import topq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  wire logic out_stall,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    ctrl_state_t state_reg, state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!sts.want_scan)
                begin
                    state_next = sts.is_flash ? ST_APPLY : ST_RESULT;
                end
                else if (sts.scan_hit)
                begin
                    if (sts.is_tick)
                    begin
                        state_next = sts.sel_pattern ? ST_READ : ST_RUN;
                    end
                    else
                    begin
                        state_next = ST_APPLY;
                    end
                end
                else if (sts.scan_last)
                begin
                    state_next = sts.is_flash ? ST_APPLY : ST_RESULT;
                end
            end
            ST_READ:   state_next = ST_RUN;
            ST_RUN:    state_next = ST_RESULT;
            ST_APPLY:  state_next = (sts.is_press && sts.found) ? ST_WR2 : ST_RESULT;
            ST_WR2:    state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_SCAN:
            begin
                cmd.scan_take = sts.want_scan && sts.scan_hit;
                cmd.scan_inc  = sts.want_scan && !sts.scan_hit && !sts.scan_last;
            end
            ST_READ:   cmd.read  = 1'b1;
            ST_RUN:    cmd.run   = 1'b1;
            ST_APPLY:  cmd.apply = 1'b1;
            ST_WR2:    cmd.wr2   = 1'b1;
            ST_RESULT: out_valid = 1'b1;
            default:   in_stall  = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

[design/topq_dp.sv]
// ----------------------------------------------------------------------------
// topq_dp
// Datapath: slot table, tick count, output state and step length RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module topq_dp
    import topq_pkg::*;
#(
    parameter int QUEUE_SLOTS   = DEF_QUEUE_SLOTS,
    parameter int PATTERN_STEPS = DEF_PATTERN_STEPS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire in_t                   in_data,
    input  wire cmd_t                  cmd,
    output sts_t                       sts,
    output out_t                       out_data
);

    localparam int SW    = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int CW    = $clog2(PATTERN_STEPS + 1);
    localparam int PW    = $clog2(QUEUE_SLOTS + 1);
    localparam int DEPTH = QUEUE_SLOTS * PATTERN_STEPS;
    localparam int AW    = $clog2(DEPTH);

    // Control state
    in_t           item_reg;
    logic [31:0]   now_reg;
    logic          cur_reg;
    logic          inv_reg;
    logic [PW-1:0] pend_reg;
    logic          acc_reg;
    logic [SW-1:0] idx_reg;
    logic          found_reg;
    logic          fill_valid_reg;
    logic [SW-1:0] fill_idx_reg;
    slot_state_t   status_reg [QUEUE_SLOTS];

    // Slot payload
    logic          pat_reg   [QUEUE_SLOTS];
    logic          lvl_reg   [QUEUE_SLOTS];
    logic [31:0]   start_reg [QUEUE_SLOTS];
    logic [CW-1:0] cnt_reg   [QUEUE_SLOTS];
    logic [CW-1:0] pos_reg   [QUEUE_SLOTS];
    logic [15:0]   rtot_reg  [QUEUE_SLOTS];
    logic [15:0]   rdone_reg [QUEUE_SLOTS];
    logic [31:0]   exp_reg   [QUEUE_SLOTS];

    // Decode
    logic          is_tick, is_set, is_press, is_flash;
    logic          match;
    logic [CW-1:0] pos_old, pos_nx;
    logic          end_pass;
    logic [15:0]   rdone_nx;
    logic          again;
    logic [23:0]   len;
    logic [31:0]   start_nx;
    logic [31:0]   start_new;
    logic          opened;
    logic [SW-1:0] f_idx;
    logic          f_valid;
    logic [CW-1:0] f_cnt;
    logic          room;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [23:0]   ram_wdata;

    function automatic logic [AW-1:0] base_addr(input logic [SW-1:0] s);
        base_addr = AW'(s) * AW'(PATTERN_STEPS);
    endfunction

    assign is_tick  = item_reg.mode == MODE_TICK;
    assign is_set   = item_reg.mode == MODE_OFF || item_reg.mode == MODE_ON
                   || item_reg.mode == MODE_TOGGLE;
    assign is_press = item_reg.mode == MODE_PRESS;
    assign is_flash = item_reg.mode == MODE_FLASH;

    // Scan match on the selected slot
    assign match = is_tick ? (status_reg[idx_reg] == SLOT_WAITING && start_reg[idx_reg] <= now_reg)
                           : (status_reg[idx_reg] == SLOT_FREE);

    assign sts.is_tick     = is_tick;
    assign sts.is_press    = is_press;
    assign sts.is_flash    = is_flash;
    assign sts.want_scan   = (is_tick && pend_reg != '0) || is_set || is_press
                          || (is_flash && item_reg.is_first);
    assign sts.scan_hit    = match;
    assign sts.scan_last   = idx_reg == SW'(QUEUE_SLOTS - 1);
    assign sts.sel_pattern = pat_reg[idx_reg];
    assign sts.found       = found_reg;

    // Run step of a due pattern
    assign pos_old   = pos_reg[idx_reg];
    assign pos_nx    = pos_old + CW'(1);
    assign end_pass  = pos_nx >= cnt_reg[idx_reg];
    assign rdone_nx  = rdone_reg[idx_reg] + 16'd1;
    assign again     = (rtot_reg[idx_reg] != 16'd0) ? (rdone_nx < rtot_reg[idx_reg])
                     : (exp_reg[idx_reg] != 32'd0 && exp_reg[idx_reg] > now_reg);
    assign start_nx  = now_reg + {8'd0, len};
    assign start_new = now_reg + 32'd1;

    // Flash step target
    assign opened  = item_reg.is_first && found_reg;
    assign f_idx   = opened ? idx_reg : fill_idx_reg;
    assign f_valid = opened || fill_valid_reg;
    assign f_cnt   = opened ? '0 : cnt_reg[f_idx];
    assign room    = f_cnt < CW'(PATTERN_STEPS);

    // Step length RAM ports
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = base_addr(idx_reg);
        ram_wdata = item_reg.duration;
        if (cmd.apply && is_press && found_reg)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.apply && is_flash && f_valid && room)
        begin
            ram_we    = 1'b1;
            ram_waddr = base_addr(f_idx) + AW'(f_cnt);
        end
        else if (cmd.wr2)
        begin
            ram_we    = 1'b1;
            ram_waddr = base_addr(idx_reg) + AW'(1);
            ram_wdata = 24'd0;
        end
    end

    assign ram_raddr = base_addr(idx_reg) + AW'(pos_old);

    topq_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH)
    ) u_steps (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.read),
        .raddr (ram_raddr),
        .rdata (len)
    );

    // Update control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg        <= '0;
            cur_reg        <= 1'b0;
            inv_reg        <= 1'b0;
            pend_reg       <= '0;
            acc_reg        <= 1'b0;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            fill_valid_reg <= 1'b0;
            fill_idx_reg   <= '0;
            for (int i = 0; i < QUEUE_SLOTS; i++)
            begin
                status_reg[i] <= SLOT_FREE;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_INVERT_POLARITY: inv_reg <= cfg_data[0];
                    CFG_ON_AFTER_RESET:  cur_reg <= cfg_data[0];
                    default:             inv_reg <= inv_reg;
                endcase
            end
            if (cmd.load)
            begin
                acc_reg   <= 1'b0;
                idx_reg   <= '0;
                found_reg <= 1'b0;
                if (in_data.mode == MODE_TICK)
                begin
                    now_reg <= now_reg + 32'd1;
                end
                // Abandon an open pattern on a new opening step
                if (in_data.mode == MODE_FLASH && in_data.is_first)
                begin
                    if (fill_valid_reg)
                    begin
                        status_reg[fill_idx_reg] <= SLOT_FREE;
                    end
                    fill_valid_reg <= 1'b0;
                end
            end
            if (cmd.scan_inc)
            begin
                idx_reg <= idx_reg + SW'(1);
            end
            if (cmd.scan_take)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.run)
            begin
                if (!pat_reg[idx_reg])
                begin
                    cur_reg                <= lvl_reg[idx_reg];
                    pend_reg               <= pend_reg - PW'(1);
                    status_reg[idx_reg]    <= SLOT_FREE;
                end
                else if (end_pass && !again)
                begin
                    cur_reg                <= 1'b0;
                    pend_reg               <= pend_reg - PW'(1);
                    status_reg[idx_reg]    <= SLOT_FREE;
                end
                else
                begin
                    cur_reg <= ~pos_old[0];
                end
            end
            if (cmd.apply && (is_set || is_press) && found_reg)
            begin
                status_reg[idx_reg] <= SLOT_WAITING;
                pend_reg            <= pend_reg + PW'(1);
                acc_reg             <= 1'b1;
            end
            if (cmd.apply && is_flash)
            begin
                // Open a new pattern unless this step also closes it
                if (opened && !item_reg.is_last)
                begin
                    status_reg[idx_reg] <= SLOT_FILLING;
                    fill_idx_reg        <= idx_reg;
                    fill_valid_reg      <= 1'b1;
                end
                if (f_valid)
                begin
                    if (room)
                    begin
                        acc_reg <= 1'b1;
                    end
                    // Close the pattern
                    if (item_reg.is_last)
                    begin
                        status_reg[f_idx] <= SLOT_WAITING;
                        pend_reg          <= pend_reg + PW'(1);
                        fill_valid_reg    <= 1'b0;
                    end
                end
            end
        end
    end

    // Update item and slot payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        if (cmd.run && pat_reg[idx_reg])
        begin
            if (end_pass)
            begin
                if (rtot_reg[idx_reg] != 16'd0)
                begin
                    rdone_reg[idx_reg] <= rdone_nx;
                end
                if (again)
                begin
                    start_reg[idx_reg] <= start_nx;
                    pos_reg[idx_reg]   <= '0;
                end
            end
            else
            begin
                pos_reg[idx_reg]   <= pos_nx;
                start_reg[idx_reg] <= start_nx;
            end
        end
        if (cmd.apply && (opened || ((is_set || is_press) && found_reg)))
        begin
            pat_reg[idx_reg]   <= !is_set;
            start_reg[idx_reg] <= start_new;
            pos_reg[idx_reg]   <= '0;
            rdone_reg[idx_reg] <= '0;
            rtot_reg[idx_reg]  <= is_flash ? item_reg.repeat_count : 16'd0;
            exp_reg[idx_reg]   <= (is_flash && item_reg.total_duration != 24'd0)
                                ? start_new + {8'd0, item_reg.total_duration} : 32'd0;
            // A new pattern holds its first step at once
            cnt_reg[idx_reg]   <= is_press ? CW'(2) : (is_flash ? CW'(1) : CW'(0));
            case (item_reg.mode)
                MODE_ON:     lvl_reg[idx_reg] <= 1'b1;
                MODE_TOGGLE: lvl_reg[idx_reg] <= ~cur_reg;
                default:     lvl_reg[idx_reg] <= 1'b0;
            endcase
        end
        if (cmd.apply && is_flash && f_valid && room && !opened)
        begin
            cnt_reg[f_idx] <= f_cnt + CW'(1);
        end
    end

    // Result fields
    assign out_data.pin_level = cur_reg ^ inv_reg;
    assign out_data.output_on = cur_reg;
    assign out_data.pending   = 3'(pend_reg);
    assign out_data.accepted  = acc_reg;

endmodule

`default_nettype wire

[design/timed_output_pattern_queue.sv]
// ----------------------------------------------------------------------------
// timed_output_pattern_queue
// Binary output driven by a small queue of timed set, press and flash requests.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one transaction per tick or request.
//   out_valid/out_stall/out_data return exactly one result per transaction.
//   cfg_we/cfg_index/cfg_data write polarity and start state while idle.
// Timing: one transaction at a time. A transaction is taken in the idle
//   state, the slot table is scanned one slot per cycle, a due pattern
//   adds a read of the step length RAM, a press adds a second RAM write.
//   The next transaction is taken the cycle after the result leaves.
// Reset: all slots free, tick count zero, output off, no pattern open.
//   Step lengths are not cleared.
// Stall: the result holds on out_data while out_stall is high and in_stall
//   stays high until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_output_pattern_queue
    import topq_pkg::*;
#(
    parameter int QUEUE_SLOTS   = DEF_QUEUE_SLOTS,
    parameter int PATTERN_STEPS = DEF_PATTERN_STEPS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_t                   in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_t                       out_data
);

    cmd_t cmd;
    sts_t sts;

    // Sequencer
    topq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Slot table and output state
    topq_dp #(
        .QUEUE_SLOTS   (QUEUE_SLOTS),
        .PATTERN_STEPS (PATTERN_STEPS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

[design/topq_checker.sv]
// ----------------------------------------------------------------------------
// topq_checker
// Port-level checks on transaction ordering of the timed output queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "timed_output_pattern_queue_assert.svh"

module topq_checker
    import topq_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire out_t out_data
);

    // Hold a stalled result
    `TOPQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

    // Go busy after taking a transaction
    `TOPQ_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall && !out_valid)

    // Never take input while a result waits
    `TOPQ_ASSERT_NOW(a_one_in_flight, out_valid, in_stall)

    // Deliver one result per transaction
    `TOPQ_ASSERT_NEXT(a_single_result, out_valid && !out_stall, !out_valid)

endmodule

bind timed_output_pattern_queue topq_checker u_topq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
